FILE: hw/rtl/cmm_pkg.sv
package cmm_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 24;

	// Ring address, window counts and the running sum.
	localparam int ADDR_W  = $clog2(WINDOW_MAX);
	localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W   = SAMPLE_BITS + CNT_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam logic [63:0] RECIP_ONE = 64'd1 << (RECIP_W - 1);

	// Configuration register.
	localparam int CFG_W      = 7;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(5);
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	// Output queue and the credit count that guards it.
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OCC_W      = $clog2(OUTQ_DEPTH + 1);

	typedef struct packed {
		logic                    vld;
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
	} emit_t;

	typedef struct packed {
		logic                   vld;
		logic [SAMPLE_BITS-1:0] mean;
		logic                   last;
	} res_t;

endpackage

FILE: hw/rtl/cmm_ram.sv
module cmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/cmm_window.sv
module cmm_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cmm_pkg::CFG_W-1:0]       wlen,
	input  logic                            clear,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cmm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                            last_in,
	input  logic                            can_issue,
	output cmm_pkg::emit_t                  emit
);
	import cmm_pkg::*;

	logic [CNT_W-1:0]        len_c;
	logic [CNT_W-1:0]        half;
	logic [CNT_W-1:0]        ahead;

	logic [ADDR_W-1:0]       wptr_q;
	logic [ADDR_W-1:0]       lo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        pend_q;
	logic [CNT_W-1:0]        bef_q;
	logic                    flush_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    sub_s1;
	logic                    fwd_s1;
	logic [SAMPLE_BITS-1:0]  fwd_data_s1;

	logic [SAMPLE_BITS-1:0]  ram_rdata;
	logic [SAMPLE_BITS-1:0]  sub_val;
	logic signed [SUM_W-1:0] sum_eff;
	logic [CNT_W-1:0]        pend_eff;
	logic [CNT_W-1:0]        cnt_eff;
	logic                    acc;
	logic                    last_now;
	logic                    do_emit;
	logic                    fin;
	logic                    do_sub;

	always_comb begin
		if (wlen == '0) begin
			len_c = CNT_W'(1);
		end else if (32'(wlen) > WINDOW_MAX) begin
			len_c = CNT_W'(WINDOW_MAX);
		end else begin
			len_c = CNT_W'(wlen);
		end
		half  = len_c >> 1;
		ahead = len_c - CNT_W'(1) - half;
	end

	// The sum register always holds the newest sample; the subtraction of the
	// sample leaving at the low end lands in the following cycle, after the read.
	assign in_ready = !flush_q && can_issue;
	assign acc      = in_valid && in_ready;
	assign sub_val  = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		sum_eff = sum_q;
		if (sub_s1) begin
			sum_eff = sum_eff - {{(SUM_W-SAMPLE_BITS){sub_val[SAMPLE_BITS-1]}}, sub_val};
		end
		if (acc) begin
			sum_eff = sum_eff + {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
		end
	end

	assign pend_eff = pend_q + CNT_W'(acc);
	assign cnt_eff  = cnt_q + CNT_W'(acc);
	assign last_now = flush_q || (acc && last_in);
	assign do_emit  = can_issue && (flush_q || (acc && (last_in || pend_eff > ahead)));
	assign fin      = do_emit && last_now && (pend_eff == CNT_W'(1));
	assign do_sub   = do_emit && !fin && (bef_q == half);

	assign emit.vld  = do_emit;
	assign emit.sum  = sum_eff;
	assign emit.cnt  = cnt_eff;
	assign emit.last = fin;

	cmm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_line (
		.clk  (clk),
		.we   (acc),
		.waddr(wptr_q),
		.wdata(sample),
		.raddr(lo_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			lo_q    <= '0;
			cnt_q   <= '0;
			pend_q  <= '0;
			bef_q   <= '0;
			flush_q <= 1'b0;
			sum_q   <= '0;
			sub_s1  <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (acc) begin
				wptr_q <= wptr_q + ADDR_W'(1);
			end
			if (clear || fin) begin
				lo_q    <= clear ? wptr_q : wptr_q + ADDR_W'(acc);
				cnt_q   <= '0;
				pend_q  <= '0;
				bef_q   <= '0;
				flush_q <= 1'b0;
				sum_q   <= '0;
				sub_s1  <= 1'b0;
				fwd_s1  <= 1'b0;
			end else begin
				sum_q   <= sum_eff;
				cnt_q   <= cnt_eff - CNT_W'(do_sub);
				pend_q  <= pend_eff - CNT_W'(do_emit);
				flush_q <= flush_q || (acc && last_in);
				if (do_emit && (bef_q != half)) begin
					bef_q <= bef_q + CNT_W'(1);
				end
				if (do_sub) begin
					lo_q <= lo_q + ADDR_W'(1);
				end
				sub_s1 <= do_sub;
				// The entry leaving is the one being written in the same cycle.
				fwd_s1 <= do_sub && acc && (wptr_q == lo_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= sample;
	end

	assert property (@(posedge clk) disable iff (!arst_n) !flush_q |-> pend_q <= ahead)
		else $error("pending count passed the look-ahead outside a flush");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q < len_c)
		else $error("running sum holds more samples than the window");
	assert property (@(posedge clk) disable iff (!arst_n) flush_q |-> !in_ready)
		else $error("input taken during the end flush");

endmodule

FILE: hw/rtl/cmm_div.sv
module cmm_div (
	input  logic           clk,
	input  logic           arst_n,
	input  cmm_pkg::emit_t emit,
	output cmm_pkg::res_t  res
);
	import cmm_pkg::*;

	logic [RECIP_W-1:0] recip_tab [WINDOW_MAX];

	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_recip
		localparam logic [RECIP_W-1:0] RV = RECIP_W'(RECIP_ONE / 64'(g + 1));
		assign recip_tab[g] = RV;
	end

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [SUM_W-1:0] sum_s1;
	logic [CNT_W-1:0]        cnt_s1;
	logic                    last_s1, last_s2, last_s3, last_s4;
	logic                    neg_s2, neg_s3, neg_s4;
	logic [SUM_W-1:0]        n_s2, n_s3;
	logic [CNT_W:0]          d_s2, d_s3;
	logic [RECIP_W-1:0]      recip_s2;
	logic [SUM_W-1:0]        q_s3, q_s4;

	logic                    neg;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W+RECIP_W-1:0] prod;
	logic [SUM_W+CNT_W:0]    qd;
	logic [SUM_W-1:0]        rem;
	logic [SUM_W-1:0]        q_signed;

	// Rounded quotient of |sum| by count is floor((2|sum| + count) / (2 count)).
	assign neg  = sum_s1[SUM_W-1];
	assign mag  = neg ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);
	// The reciprocal estimate is low by at most one; one compare fixes it.
	assign prod = n_s2 * recip_s2;
	assign qd   = q_s3 * d_s3;
	assign rem  = n_s3 - qd[SUM_W-1:0];
	assign q_signed = neg_s4 ? -q_s4 : q_s4;

	assign res.vld  = vld_s4;
	assign res.mean = q_signed[SAMPLE_BITS-1:0];
	assign res.last = last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= emit.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1   <= emit.sum;
		cnt_s1   <= emit.cnt;
		last_s1  <= emit.last;

		n_s2     <= (mag << 1) + SUM_W'(cnt_s1);
		d_s2     <= {cnt_s1, 1'b0};
		recip_s2 <= recip_tab[ADDR_W'(cnt_s1 - CNT_W'(1))];
		neg_s2   <= neg;
		last_s2  <= last_s1;

		q_s3     <= prod[SUM_W+RECIP_W-1:RECIP_W];
		n_s3     <= n_s2;
		d_s3     <= d_s2;
		neg_s3   <= neg_s2;
		last_s3  <= last_s2;

		q_s4     <= q_s3 + SUM_W'(rem >= SUM_W'(d_s3));
		neg_s4   <= neg_s3;
		last_s4  <= last_s3;
	end

endmodule

FILE: hw/rtl/cmm_outq.sv
module cmm_outq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmm_pkg::res_t                   res,
	output logic                            tvalid,
	input  logic                            tready,
	output logic [cmm_pkg::SAMPLE_BITS-1:0] tdata,
	output logic                            tlast
);
	import cmm_pkg::*;

	logic [SAMPLE_BITS:0] mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_q;
	logic [OUTQ_AW-1:0]   rd_q;
	logic [OCC_W-1:0]     count_q;
	logic                 pop;

	assign tvalid = (count_q != '0);
	assign pop    = tvalid && tready;
	assign tdata  = mem_q[rd_q][SAMPLE_BITS:1];
	assign tlast  = mem_q[rd_q][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (res.vld) begin
				wr_q <= wr_q + OUTQ_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OUTQ_AW'(1);
			end
			count_q <= count_q + OCC_W'(res.vld) - OCC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			mem_q[wr_q] <= {res.mean, res.last};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |-> (count_q < OCC_W'(OUTQ_DEPTH)) || pop)
		else $error("output queue overflow");

endmodule

FILE: hw/rtl/centered_moving_mean.sv
// Centered moving mean over a stream of signed 24-bit samples. Each position
// gets the rounded mean (ties away from zero) of the samples from half before
// it to ahead after it, half = L/2 and ahead = L-1-half for the window length
// L in register window_length (0 acts as 1, above 64 as 64); at both ends of
// a sequence the window shrinks and the divisor is the number of samples
// actually summed. A sequence ends with the sample that carries tlast. One
// sample is taken per cycle while s_axis_tready is high, and each sample once
// the sequence is ahead deep releases the mean of the position ahead samples
// back. The tlast sample starts a flush that gives every pending mean, one
// per cycle while credits are free, with s_axis_tready low; the final mean
// carries tlast. The window lives in a 64-entry delay memory and a running
// sum; an eight-entry output queue lets the stream run at full rate while the
// sink is ready and throttles input when it is not. Writing window_length
// abandons any sequence in progress; write it only while the block is idle.
module centered_moving_mean (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cmm_pkg::PADDR_W-1:0]       paddr,
	input  logic [cmm_pkg::PDATA_W-1:0]       pwdata,
	output logic [cmm_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	// Input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [cmm_pkg::SAMPLE_BITS-1:0]   s_axis_tdata,   // [23:0] sample
	input  logic                              s_axis_tlast,   // last_in
	// Output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [cmm_pkg::SAMPLE_BITS-1:0]   m_axis_tdata,   // [23:0] mean
	output logic                              m_axis_tlast    // last_out
);
	import cmm_pkg::*;

	logic [CFG_W-1:0] wlen_q;
	logic [OCC_W-1:0] occ_q;
	logic             cfg_wr;
	logic             can_issue;
	logic             pop;
	emit_t            emit;
	res_t             res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[PADDR_W-1] == REG_WINDOW_LENGTH);
	assign prdata = (paddr[PADDR_W-1] == REG_WINDOW_LENGTH) ? PDATA_W'(wlen_q) : '0;

	// Every mean in flight or queued holds a credit, so the queue never overflows.
	assign can_issue = (occ_q < OCC_W'(OUTQ_DEPTH));
	assign pop       = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= LEN_RESET;
			occ_q  <= '0;
		end else begin
			if (cfg_wr) begin
				wlen_q <= pwdata[CFG_W-1:0];
			end
			occ_q <= occ_q + OCC_W'(emit.vld) - OCC_W'(pop);
		end
	end

	cmm_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.wlen     (wlen_q),
		.clear    (cfg_wr),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sample   (s_axis_tdata),
		.last_in  (s_axis_tlast),
		.can_issue(can_issue),
		.emit     (emit)
	);

	cmm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.emit  (emit),
		.res   (res)
	);

	cmm_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.res   (res),
		.tvalid(m_axis_tvalid),
		.tready(m_axis_tready),
		.tdata (m_axis_tdata),
		.tlast (m_axis_tlast)
	);

	assert property (@(posedge clk) disable iff (!arst_n) m_axis_tvalid |-> occ_q != '0)
		else $error("output beat without a credit held");
	assert property (@(posedge clk) disable iff (!arst_n) emit.vld |-> can_issue)
		else $error("mean issued without a free credit");

endmodule
